>>> rtl/clnf_pkg.sv
// Shared types, constants and helpers for the character LCD number formatter.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps

package clnf_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int COUNT_W     = 5;
    localparam int VALUE_W     = 16;
    localparam int DEC_DIGITS  = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  CMD_SET_CURSOR = 8'h80;
    localparam logic [7:0]  LINE2_OFFSET   = 8'h40;
    localparam logic [7:0]  ASCII_ZERO     = 8'h30;
    localparam logic [7:0]  ASCII_UPPER_A  = 8'h41;
    localparam logic [7:0]  ASCII_PLUS     = 8'h2B;
    localparam logic [7:0]  ASCII_MINUS    = 8'h2D;
    localparam logic [3:0]  DEC_BASE       = 4'd10;
    localparam logic [1:0]  LINE_TOP       = 2'd1;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [31:0] DIV10_RECIP = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [2:0] {
        OP_CHAR = 3'd0,
        OP_UDEC = 3'd1,
        OP_SDEC = 3'd2,
        OP_HEX  = 3'd3,
        OP_BIN  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]         op;
        logic [1:0]         line;
        logic [4:0]         column;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
    } t_req;

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_res;
        logic       last;
    } t_res;

    // One classified request as it sits in the queue
    typedef struct packed {
        t_op                op;
        logic [7:0]         cursor;
        logic               neg;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CURSOR,
        ST_SIGN,
        ST_DATA,
        ST_DIGIT
    } t_state;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] ch;
        if (d < DEC_BASE) begin
            ch = ASCII_ZERO + {4'b0, d};
        end else begin
            ch = ASCII_UPPER_A + {4'b0, d} - {4'b0, DEC_BASE};
        end
        return ch;
    endfunction

endpackage

>>> rtl/char_lcd_number_formatter.sv
// Top level of the character LCD number formatter.
// Instantiates clnf_front, clnf_queue and clnf_back; depends on clnf_pkg.
`timescale 1ns / 1ps

// Turns one display request (character, unsigned or signed decimal, hex or
// binary) into a stream of bytes for an HD44780-style bus: a set-cursor
// command, an optional sign, then the character or the digits most
// significant first, with last marking the final byte. Unknown ops are
// taken and produce nothing. Requests pass through a two-entry queue, so the
// input side keeps taking requests while earlier ones are being sent. The
// byte sequencer takes a job from the queue, converts the magnitude of a
// decimal op one digit per cycle through a divide-by-ten multiplier, then
// emits the cursor, sign, character or digit bytes in turn. The output is
// registered; a stall on it holds the sequencer before its next byte.
module char_lcd_number_formatter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clnf_pkg::t_req i_in_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output clnf_pkg::t_res o_out_data,
    output logic           o_out_valid,
    input  logic           i_out_stall
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    clnf_pkg::t_job job_in;
    clnf_pkg::t_job job_out;

    clnf_front u_front (
        .i_req   (i_in_data),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    clnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    clnf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_res   (o_out_data),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall)
    );

endmodule

>>> rtl/clnf_front.sv
// Request front end: accepts requests, drops unknown ops, builds cursor byte,
// sign, magnitude and saturated digit count. Depends on clnf_pkg.
`timescale 1ns / 1ps

module clnf_front (
    input  clnf_pkg::t_req i_req,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_full,
    output logic           o_push,
    output clnf_pkg::t_job o_job
);

    logic                         op_ok;
    logic [7:0]                   cur;
    logic                         neg;
    logic [clnf_pkg::VALUE_W-1:0] mag;
    logic [clnf_pkg::COUNT_W-1:0] cnt;

    always_comb begin
        case (clnf_pkg::t_op'(i_req.op))
            clnf_pkg::OP_CHAR, clnf_pkg::OP_UDEC, clnf_pkg::OP_SDEC,
            clnf_pkg::OP_HEX, clnf_pkg::OP_BIN: op_ok = 1'b1;
            default: op_ok = 1'b0;
        endcase
    end

    always_comb begin
        // column-1 wraps in 8 bits, as does the second-line offset
        cur = {3'b0, i_req.column} - 8'd1;
        if (i_req.line != clnf_pkg::LINE_TOP) begin
            cur = cur + clnf_pkg::LINE2_OFFSET;
        end
        cur = cur | clnf_pkg::CMD_SET_CURSOR;
    end

    always_comb begin
        neg = (clnf_pkg::t_op'(i_req.op) == clnf_pkg::OP_SDEC) && i_req.value[15];
        mag = neg ? (~i_req.value + 16'd1) : i_req.value;
    end

    always_comb begin
        if ({1'b0, i_req.digit_count} > 6'(clnf_pkg::MAX_DIGITS)) begin
            cnt = clnf_pkg::COUNT_W'(clnf_pkg::MAX_DIGITS);
        end else begin
            cnt = i_req.digit_count;
        end
    end

    assign o_job.op     = clnf_pkg::t_op'(i_req.op);
    assign o_job.cursor = cur;
    assign o_job.neg    = neg;
    assign o_job.value  = mag;
    assign o_job.count  = cnt;

    // unknown ops are taken and dropped, so they never wait for queue space
    assign o_stall = i_full && op_ok;
    assign o_push  = i_valid && op_ok && !i_full;

endmodule

>>> rtl/clnf_queue.sv
// Short job queue between front end and byte sequencer.
// Depends on clnf_pkg.
`timescale 1ns / 1ps

module clnf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clnf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output clnf_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(clnf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(clnf_pkg::QUEUE_DEPTH + 1);

    clnf_pkg::t_job r_mem [clnf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(clnf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> rtl/clnf_back.sv
// Byte sequencer: pops a job, converts decimal magnitudes one digit a cycle, then emits
// cursor, sign, character or digit bytes through an output register. Depends on clnf_pkg.
`timescale 1ns / 1ps

module clnf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  clnf_pkg::t_job i_job,
    output logic           o_pop,
    output clnf_pkg::t_res o_res,
    output logic           o_valid,
    input  logic           i_stall
);

    clnf_pkg::t_state r_state;
    clnf_pkg::t_state n_state;

    clnf_pkg::t_job               r_job;
    logic [clnf_pkg::VALUE_W-1:0] r_mag;
    logic [2:0]                   r_ci;
    logic [3:0]                   r_dec [clnf_pkg::DEC_DIGITS];
    logic [clnf_pkg::COUNT_W-1:0] r_pos;
    clnf_pkg::t_res               r_out;
    logic                         r_out_valid;

    logic                         can_load;
    logic                         load;
    clnf_pkg::t_res               n_res;
    logic                         is_dec;
    logic [31:0]                  prod;
    logic [clnf_pkg::VALUE_W-1:0] quot;
    logic [clnf_pkg::VALUE_W-1:0] rem_full;
    logic [clnf_pkg::COUNT_W-1:0] idx;
    logic [3:0]                   digit;

    assign can_load = !r_out_valid || !i_stall;
    assign is_dec   = (i_job.op == clnf_pkg::OP_UDEC) || (i_job.op == clnf_pkg::OP_SDEC);

    // divide by ten through the reciprocal
    assign prod     = {16'b0, r_mag} * clnf_pkg::DIV10_RECIP;
    assign quot     = clnf_pkg::VALUE_W'(prod >> clnf_pkg::DIV10_SHIFT);
    assign rem_full = r_mag - (quot << 3) - (quot << 1);

    assign idx = r_pos - clnf_pkg::COUNT_W'(1);

    always_comb begin
        digit = 4'd0;
        case (r_job.op)
            clnf_pkg::OP_HEX: begin
                if (idx < clnf_pkg::COUNT_W'(4)) begin
                    digit = 4'(r_job.value >> {idx[1:0], 2'b00});
                end
            end
            clnf_pkg::OP_BIN: begin
                if (idx < clnf_pkg::COUNT_W'(16)) begin
                    digit = {3'b0, r_job.value[idx[3:0]]};
                end
            end
            clnf_pkg::OP_UDEC, clnf_pkg::OP_SDEC: begin
                if (idx < clnf_pkg::COUNT_W'(clnf_pkg::DEC_DIGITS)) begin
                    digit = r_dec[idx[2:0]];
                end
            end
            default: digit = 4'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clnf_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    n_state = is_dec ? clnf_pkg::ST_CONV : clnf_pkg::ST_CURSOR;
                end
            end
            clnf_pkg::ST_CONV: begin
                if (r_ci == 3'(clnf_pkg::DEC_DIGITS - 1)) begin
                    n_state = clnf_pkg::ST_CURSOR;
                end
            end
            clnf_pkg::ST_CURSOR: begin
                if (can_load) begin
                    if (r_job.op == clnf_pkg::OP_CHAR) begin
                        n_state = clnf_pkg::ST_DATA;
                    end else if (r_job.op == clnf_pkg::OP_SDEC) begin
                        n_state = clnf_pkg::ST_SIGN;
                    end else if (r_pos == '0) begin
                        n_state = clnf_pkg::ST_IDLE;
                    end else begin
                        n_state = clnf_pkg::ST_DIGIT;
                    end
                end
            end
            clnf_pkg::ST_SIGN: begin
                if (can_load) begin
                    n_state = (r_pos == '0) ? clnf_pkg::ST_IDLE : clnf_pkg::ST_DIGIT;
                end
            end
            clnf_pkg::ST_DATA: begin
                if (can_load) begin
                    n_state = clnf_pkg::ST_IDLE;
                end
            end
            clnf_pkg::ST_DIGIT: begin
                if (can_load && r_pos == clnf_pkg::COUNT_W'(1)) begin
                    n_state = clnf_pkg::ST_IDLE;
                end
            end
            default: n_state = clnf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        n_res = '0;
        case (r_state)
            clnf_pkg::ST_IDLE: begin
                o_pop = !i_empty;
            end
            clnf_pkg::ST_CURSOR: begin
                load           = can_load;
                n_res.is_data  = 1'b0;
                n_res.byte_res = r_job.cursor;
                n_res.last     = (r_job.op != clnf_pkg::OP_CHAR)
                                 && (r_job.op != clnf_pkg::OP_SDEC) && (r_pos == '0);
            end
            clnf_pkg::ST_SIGN: begin
                load           = can_load;
                n_res.is_data  = 1'b1;
                n_res.byte_res = r_job.neg ? clnf_pkg::ASCII_MINUS : clnf_pkg::ASCII_PLUS;
                n_res.last     = (r_pos == '0);
            end
            clnf_pkg::ST_DATA: begin
                load           = can_load;
                n_res.is_data  = 1'b1;
                n_res.byte_res = r_job.value[7:0];
                n_res.last     = 1'b1;
            end
            clnf_pkg::ST_DIGIT: begin
                load           = can_load;
                n_res.is_data  = 1'b1;
                n_res.byte_res = clnf_pkg::digit_ascii(digit);
                n_res.last     = (r_pos == clnf_pkg::COUNT_W'(1));
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clnf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_res;
        end
        if (o_pop) begin
            r_job <= i_job;
            r_mag <= i_job.value;
            r_ci  <= '0;
            r_pos <= i_job.count;
        end
        if (r_state == clnf_pkg::ST_CONV) begin
            r_dec[r_ci] <= rem_full[3:0];
            r_mag       <= quot;
            r_ci        <= r_ci + 3'd1;
        end
        // advance toward the least significant digit
        if (r_state == clnf_pkg::ST_DIGIT && load) begin
            r_pos <= r_pos - clnf_pkg::COUNT_W'(1);
        end
    end

    assign o_res   = r_out;
    assign o_valid = r_out_valid;

endmodule

>>> tb/tb_char_lcd_number_formatter.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_number_formatter: sends display requests,
// predicts the cursor/sign/digit byte stream of each and checks every output transfer.
// Depends on rtl/clnf_pkg.sv and the RTL of the block.

module tb_char_lcd_number_formatter;
    import clnf_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_FROM   = 150;
    localparam int QUIET_TO     = 230;
    localparam int PAUSE_AT     = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    // first op code the block does not know; the next two are unknown as well
    localparam logic [2:0] OP_FIRST_UNKNOWN = 3'd5;

    // Expected display bytes, in bus order, for every accepted request
    class byte_scoreboard;
        t_res expected_q[$];
        int   requests;
        int   ignored;
        int   checked;
        int   errors;

        function void note_request(t_req r);
            logic [7:0]  cursor;
            logic [16:0] mag;
            logic [3:0]  digs [MAX_DIGITS];
            logic [7:0]  seq [$];
            int          n;
            t_res        b;
            requests++;
            if (r.op > OP_BIN) begin
                ignored++;
                return;
            end
            // column-1 and the second-line offset both wrap in 8 bits
            cursor = {3'b0, r.column} - 8'd1;
            if (r.line != LINE_TOP) begin
                cursor = cursor + LINE2_OFFSET;
            end
            seq.push_back(cursor | CMD_SET_CURSOR);
            if (r.op == OP_CHAR) begin
                seq.push_back(r.value[7:0]);
            end else begin
                n = (r.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(r.digit_count);
                mag = {1'b0, r.value};
                if (r.op == OP_SDEC) begin
                    if (r.value[VALUE_W-1]) begin
                        seq.push_back(ASCII_MINUS);
                        mag = 17'h10000 - mag;
                    end else begin
                        seq.push_back(ASCII_PLUS);
                    end
                end
                for (int p = 0; p < MAX_DIGITS; p++) begin
                    case (r.op)
                        OP_HEX: begin
                            digs[p] = (p < 4) ? r.value[4*p +: 4] : 4'd0;
                        end
                        OP_BIN: begin
                            digs[p] = (p < VALUE_W) ? {3'b0, r.value[p]} : 4'd0;
                        end
                        default: begin
                            digs[p] = 4'(mag % 10);
                            mag = mag / 10;
                        end
                    endcase
                end
                for (int p = n; p > 0; p--) begin
                    if (digs[p-1] < 4'd10) begin
                        seq.push_back(ASCII_ZERO + {4'b0, digs[p-1]});
                    end else begin
                        seq.push_back(ASCII_UPPER_A + {4'b0, digs[p-1]} - 8'd10);
                    end
                end
            end
            // only the leading cursor byte is a command
            for (int i = 0; i < seq.size(); i++) begin
                b.is_data  = (i != 0);
                b.byte_res = seq[i];
                b.last     = (i == seq.size() - 1);
                expected_q.push_back(b);
            end
        endfunction

        function void check_byte(t_res got);
            t_res want;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte: is_data %b byte %h last %b",
                         $time, got.is_data, got.byte_res, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch (is_data byte last): expected %b %h %b, got %b %h %b",
                         $time, want.is_data, want.byte_res, want.last,
                         got.is_data, got.byte_res, got.last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    t_req i_in_data   = '0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    t_res o_out_data;
    logic o_out_valid;

    byte_scoreboard sb = new();
    bit   in_idle_on   = 1'b1;
    bit   out_idle_on  = 1'b1;
    bit   hold_request = 1'b0;
    int   cycle_count  = 0;

    char_lcd_number_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_request(i_in_data);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_byte(o_out_data);
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= out_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d bytes outstanding", $time, sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_request(input t_req r, input bit may_idle);
        while (may_idle && in_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_data  <= r;
        i_in_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    task automatic send_fields(input logic [2:0] op, input logic [1:0] line,
                               input logic [4:0] column, input logic [15:0] value,
                               input logic [4:0] digit_count);
        t_req r;
        r.op          = op;
        r.line        = line;
        r.column      = column;
        r.value       = value;
        r.digit_count = digit_count;
        send_request(r, 1'b1);
    endtask

    // Drop valid and hold until every predicted byte has been seen
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_req random_request();
        t_req r;
        if ($urandom_range(0, 99) < 6) begin
            r.op = OP_FIRST_UNKNOWN + 3'($urandom_range(0, 2));
        end else begin
            r.op = 3'($urandom_range(0, 4));
        end
        r.line = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 85) begin
            r.column = 5'($urandom_range(1, 16));
        end else begin
            r.column = 5'($urandom_range(0, 31));
        end
        case ($urandom_range(0, 3))
            0, 1: r.value = 16'($urandom);
            2:    r.value = 16'($urandom_range(0, 99));
            default: begin
                r.value = ($urandom_range(0, 1) ? 16'h8000 : 16'hFFFF)
                          ^ 16'($urandom_range(0, 15));
            end
        endcase
        if ($urandom_range(0, 99) < 85) begin
            r.digit_count = 5'($urandom_range(0, MAX_DIGITS));
        end else begin
            r.digit_count = 5'($urandom_range(MAX_DIGITS + 1, 31));
        end
        return r;
    endfunction

    initial begin : stimulus
        t_req r;
        int   sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every op and the corner cases
        send_fields(OP_CHAR, LINE_TOP, 5'd1, 16'h0041, 5'd0);
        send_fields(OP_CHAR, 2'd2, 5'd16, 16'hA5FF, 5'd31);
        send_fields(OP_CHAR, LINE_TOP, 5'd0, 16'h0000, 5'd0);
        send_fields(OP_CHAR, 2'd0, 5'd0, 16'h0020, 5'd0);
        send_fields(OP_CHAR, 2'd3, 5'd31, 16'h007E, 5'd0);
        send_fields(OP_UDEC, LINE_TOP, 5'd5, 16'hFFFF, 5'd5);
        send_fields(OP_UDEC, 2'd2, 5'd1, 16'h0000, 5'd0);
        send_fields(OP_UDEC, LINE_TOP, 5'd3, 16'd12345, 5'd16);
        send_fields(OP_UDEC, 2'd2, 5'd8, 16'd987, 5'd31);
        send_fields(OP_SDEC, LINE_TOP, 5'd1, 16'h8000, 5'd5);
        send_fields(OP_SDEC, 2'd2, 5'd2, 16'h0000, 5'd3);
        send_fields(OP_SDEC, LINE_TOP, 5'd9, 16'h7FFF, 5'd16);
        send_fields(OP_SDEC, 2'd3, 5'd4, 16'hFFFF, 5'd1);
        send_fields(OP_SDEC, LINE_TOP, 5'd6, 16'h8001, 5'd0);
        send_fields(OP_HEX, LINE_TOP, 5'd12, 16'hABCD, 5'd4);
        send_fields(OP_HEX, 2'd2, 5'd1, 16'h1234, 5'd16);
        send_fields(OP_HEX, 2'd0, 5'd7, 16'hFEDC, 5'd0);
        send_fields(OP_BIN, LINE_TOP, 5'd1, 16'hA5A5, 5'd16);
        send_fields(OP_BIN, 2'd2, 5'd16, 16'hFFFF, 5'd31);
        send_fields(OP_BIN, LINE_TOP, 5'd2, 16'h0001, 5'd0);
        send_fields(OP_FIRST_UNKNOWN, LINE_TOP, 5'd1, 16'h1111, 5'd4);
        send_fields(OP_FIRST_UNKNOWN + 3'd1, 2'd2, 5'd2, 16'h2222, 5'd4);
        send_fields(OP_FIRST_UNKNOWN + 3'd2, 2'd3, 5'd3, 16'h3333, 5'd4);

        // hold the output off while requests keep coming, so the queue backs up
        hold_request = 1'b1;
        repeat (12) send_request(random_request(), 1'b0);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            in_idle_on  = !(sent >= QUIET_FROM && sent < QUIET_TO);
            out_idle_on = in_idle_on;
            r = random_request();
            send_request(r, 1'b1);
            if (r.op <= OP_BIN) begin
                sent++;
                if (sent == PAUSE_AT) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
        end

        $display("Ran %0d requests (%0d with unknown ops) in %0d cycles; %0d bytes checked,",
                 sb.requests, sb.ignored, cycle_count, sb.checked);
        $display("including a long output hold-off, a no-idle stretch and a full drain pause.");
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
